FILE: rtl/pee_pkg.sv
`timescale 1ns / 1ps
// Package for the prefix expression evaluator: beat types, character codes,
// operation decode and the sequencer state type. No dependencies.
package pee_pkg;

    localparam int WORD_W = 32;
    localparam int STACK_DEPTH_DEFAULT = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic [WORD_W-1:0] MOST_NEGATIVE = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic [7:0] symbol;
        logic       final_symbol;
    } in_beat_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     underflow;
        logic                     divide_by_zero;
    } out_beat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_DROP
    } op_t;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_POP_B    = 7'b0000010,
        S_EXEC     = 7'b0000100,
        S_DIV      = 7'b0001000,
        S_PUSH     = 7'b0010000,
        S_FIN_RD   = 7'b0100000,
        S_FIN_WAIT = 7'b1000000
    } state_t;

    function automatic op_t decode_op(input logic [7:0] sym);
        op_t op;
        if (sym >= CHAR_ZERO && sym <= CHAR_NINE) begin
            op = OP_PUSH;
        end else if (sym == CHAR_PLUS) begin
            op = OP_ADD;
        end else if (sym == CHAR_MINUS) begin
            op = OP_SUB;
        end else if (sym == CHAR_STAR) begin
            op = OP_MUL;
        end else if (sym == CHAR_SLASH) begin
            op = OP_DIV;
        end else begin
            op = OP_DROP;
        end
        return op;
    endfunction

endpackage

FILE: rtl/pee_stack_mem.sv
`timescale 1ns / 1ps
// Operand stack storage: one write port and one registered read port.
// Depends on pee_pkg for the word width.
module pee_stack_mem
    import pee_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/pee_divider.sv
`timescale 1ns / 1ps
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on pee_pkg for the word width and status type.
module pee_divider
    import pee_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] num,
    input  logic [WORD_W-1:0] den,
    output logic [WORD_W-1:0] quotient,
    output div_status_t       status
);

    localparam int SW = $clog2(WORD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SW-1:0]     step_reg, step_next;
    logic              neg_reg, neg_next;
    logic [WORD_W-1:0] quot_reg, quot_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] den_reg, den_next;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg, quot_reg[WORD_W-1]};
        diff      = rem_sh - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = SW'(WORD_W);
            neg_next  = num[WORD_W-1] ^ den[WORD_W-1];
            quot_next = num[WORD_W-1] ? (~num + 1'b1) : num;
            den_next  = den[WORD_W-1] ? (~den + 1'b1) : den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W])
            begin
                rem_next  = diff[WORD_W-1:0];
                quot_next = {quot_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[WORD_W-1:0];
                quot_next = {quot_reg[WORD_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == SW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign quotient    = neg_reg ? (~quot_reg + 1'b1) : quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

FILE: rtl/prefix_expression_evaluator_unit.sv
`timescale 1ns / 1ps
// Prefix expression evaluator: digits are pushed from idle; +, - and * pop two operands,
// execute and push; / runs the one-bit-per-cycle divider, or pushes zero and flags a
// zero divisor; other characters pop two operands and push nothing. A final character
// adds a result pop; the result beat is registered and new input is taken while it waits.
// Stack memory has one read and one write port; all accesses are sequenced.
// Reset clears the stack count, flags and control; stack contents are not cleared.
module prefix_expression_evaluator_unit
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      expr_valid,
    output logic      expr_stall,
    input  in_beat_t  expr_beat,
    output logic      result_valid,
    input  logic      result_stall,
    output out_beat_t result_beat
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              uflow_reg, uflow_next;
    logic              zdiv_reg, zdiv_next;
    logic              a_empty_reg, a_empty_next;
    logic              b_empty_reg, b_empty_next;
    logic              last_reg, last_next;
    op_t               op_reg, op_next;
    logic [WORD_W-1:0] left_reg, left_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic              result_valid_reg, result_valid_next;
    out_beat_t         result_beat_reg, result_beat_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic [CW-1:0]     count_dec;
    logic              not_full;
    logic              accept;
    logic              out_free;
    logic [WORD_W-1:0] right_val;
    logic              div_start;
    logic [WORD_W-1:0] div_quot;
    div_status_t       div_status;
    op_t               in_op;

    pee_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pee_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (left_reg),
        .den      (right_val),
        .quotient (div_quot),
        .status   (div_status)
    );

    assign expr_stall = (state_reg != S_IDLE);
    assign accept     = expr_valid && !expr_stall;
    assign out_free   = !result_valid_reg || !result_stall;
    assign count_dec  = count_reg - 1'b1;
    assign not_full   = (count_reg < CW'(STACK_DEPTH));
    assign right_val  = b_empty_reg ? MOST_NEGATIVE : rd_data;
    assign in_op      = decode_op(expr_beat.symbol);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        uflow_next        = uflow_reg;
        zdiv_next         = zdiv_reg;
        a_empty_next      = a_empty_reg;
        b_empty_next      = b_empty_reg;
        last_next         = last_reg;
        op_next           = op_reg;
        left_next         = left_reg;
        res_next          = res_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_beat_next  = result_beat_reg;
        wr_en             = 1'b0;
        wr_addr           = count_reg[AW-1:0];
        wr_data           = res_reg;
        rd_en             = 1'b0;
        rd_addr           = count_dec[AW-1:0];
        div_start         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = in_op;
                    last_next = expr_beat.final_symbol;
                    if (in_op == OP_PUSH)
                    begin
                        wr_data = WORD_W'(expr_beat.symbol - CHAR_ZERO);
                        if (not_full)
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        state_next = expr_beat.final_symbol ? S_FIN_RD : S_IDLE;
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            a_empty_next = 1'b1;
                            uflow_next   = 1'b1;
                        end
                        else
                        begin
                            a_empty_next = 1'b0;
                            rd_en        = 1'b1;
                            count_next   = count_dec;
                        end
                        state_next = S_POP_B;
                    end
                end
            end
            S_POP_B:
            begin
                left_next = a_empty_reg ? MOST_NEGATIVE : rd_data;
                if (count_reg == '0)
                begin
                    b_empty_next = 1'b1;
                    uflow_next   = 1'b1;
                end
                else
                begin
                    b_empty_next = 1'b0;
                    rd_en        = 1'b1;
                    count_next   = count_dec;
                end
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        res_next   = left_reg + right_val;
                        state_next = S_PUSH;
                    end
                    OP_SUB:
                    begin
                        res_next   = left_reg - right_val;
                        state_next = S_PUSH;
                    end
                    OP_MUL:
                    begin
                        res_next   = left_reg * right_val;
                        state_next = S_PUSH;
                    end
                    OP_DIV:
                    begin
                        if (right_val == '0)
                        begin
                            zdiv_next  = 1'b1;
                            res_next   = '0;
                            state_next = S_PUSH;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = last_reg ? S_FIN_RD : S_IDLE;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    res_next   = div_quot;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (not_full)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = last_reg ? S_FIN_RD : S_IDLE;
            end
            S_FIN_RD:
            begin
                if (count_reg == '0)
                begin
                    a_empty_next = 1'b1;
                    uflow_next   = 1'b1;
                end
                else
                begin
                    a_empty_next = 1'b0;
                    rd_en        = 1'b1;
                end
                state_next = S_FIN_WAIT;
            end
            S_FIN_WAIT:
            begin
                if (out_free)
                begin
                    result_valid_next               = 1'b1;
                    result_beat_next.value          = a_empty_reg ? MOST_NEGATIVE : rd_data;
                    result_beat_next.underflow      = uflow_reg;
                    result_beat_next.divide_by_zero = zdiv_reg;
                    count_next                      = '0;
                    uflow_next                      = 1'b0;
                    zdiv_next                       = 1'b0;
                    state_next                      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            uflow_reg        <= 1'b0;
            zdiv_reg         <= 1'b0;
            a_empty_reg      <= 1'b0;
            b_empty_reg      <= 1'b0;
            last_reg         <= 1'b0;
            op_reg           <= OP_DROP;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            uflow_reg        <= uflow_next;
            zdiv_reg         <= zdiv_next;
            a_empty_reg      <= a_empty_next;
            b_empty_reg      <= b_empty_next;
            last_reg         <= last_next;
            op_reg           <= op_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg        <= left_next;
        res_reg         <= res_next;
        result_beat_reg <= result_beat_next;
    end

    assign result_valid = result_valid_reg;
    assign result_beat  = result_beat_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count exceeds depth");

    a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> not_full)
        else $error("stack write while full");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == S_EXEC) && !div_status.busy)
        else $error("divider started while busy");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN_WAIT) && out_free |=>
            (count_reg == '0) && !uflow_reg && !zdiv_reg && result_valid_reg)
        else $error("expression end did not clear the stack");

endmodule

FILE: verif/tb_prefix_expression_evaluator_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for prefix_expression_evaluator_unit: a directed table and random
// expressions go in beat by beat; each result is checked against a stack mirror or a typed row.
// Depends on pee_pkg and the RTL of the unit; needs nothing else.
module tb_prefix_expression_evaluator_unit;
    import pee_pkg::*;

    localparam int STACK_SLOTS = STACK_DEPTH_DEFAULT;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 60;

    localparam logic [7:0] SYM_OTHER = 8'h78;
    localparam logic [7:0] SYM_NUL = 8'h00;
    localparam logic [7:0] SYM_HIGH = 8'hFF;

    typedef struct packed {
        logic [7:0]        symbol;
        logic              final_symbol;
        logic              typed;
        logic [WORD_W-1:0] value;
        logic              underflow;
        logic              divide_by_zero;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      expr_valid;
    logic      expr_stall;
    in_beat_t  expr_beat;
    logic      result_valid;
    logic      result_stall;
    out_beat_t result_beat;

    logic [WORD_W-1:0] operand_mirror [STACK_SLOTS];
    int unsigned       mirror_count;
    bit                mirror_underflow;
    bit                mirror_div_zero;
    out_beat_t         pending_results [$];
    out_beat_t         oldest_result;
    int                error_count = 0;
    int                sent_count = 0;
    int                stall_left = 0;
    int                stall_pick;
    bit                steady = 1'b0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CHAR_PLUS,  1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
        '{SYM_OTHER,  1'b1, 1'b1, MOST_NEGATIVE, 1'b1, 1'b0},
        '{CHAR_ZERO,  1'b1, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
        '{CHAR_NINE,  1'b1, 1'b1, 32'h0000_0009, 1'b0, 1'b0},
        '{8'h30,      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{8'h37,      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{CHAR_SLASH, 1'b1, 1'b1, 32'h0000_0000, 1'b0, 1'b1},
        '{8'h38,      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{8'h33,      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{CHAR_MINUS, 1'b1, 1'b0, 32'h0,         1'b0, 1'b0},
        '{8'h39,      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{8'h39,      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{CHAR_STAR,  1'b1, 1'b0, 32'h0,         1'b0, 1'b0},
        '{8'h32,      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{8'h37,      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{8'h30,      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{CHAR_MINUS, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{CHAR_SLASH, 1'b1, 1'b0, 32'h0,         1'b0, 1'b0},
        '{8'h35,      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{SYM_HIGH,   1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{SYM_NUL,    1'b1, 1'b1, MOST_NEGATIVE, 1'b1, 1'b0},
        '{8'h31,      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{8'h32,      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{8'h33,      1'b1, 1'b1, 32'h0000_0003, 1'b0, 1'b0},
        '{CHAR_PLUS,  1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0}
    };

    prefix_expression_evaluator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .expr_valid   (expr_valid),
        .expr_stall   (expr_stall),
        .expr_beat    (expr_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] digit_symbol(input int unsigned n);
        return CHAR_ZERO + 8'(n);
    endfunction

    function automatic void mirror_push(input logic [WORD_W-1:0] v);
        if (mirror_count < STACK_SLOTS) begin
            operand_mirror[mirror_count] = v;
            mirror_count++;
        end
    endfunction

    function automatic logic [WORD_W-1:0] mirror_pop();
        if (mirror_count == 0) begin
            mirror_underflow = 1'b1;
            return MOST_NEGATIVE;
        end
        mirror_count--;
        return operand_mirror[mirror_count];
    endfunction

    function automatic logic [WORD_W-1:0] truncated_quotient(input logic [WORD_W-1:0] num,
                                                             input logic [WORD_W-1:0] den);
        logic [WORD_W-1:0] num_mag;
        logic [WORD_W-1:0] den_mag;
        logic [WORD_W-1:0] quo;
        if (den == '0) begin
            mirror_div_zero = 1'b1;
            return '0;
        end
        num_mag = num[WORD_W-1] ? -num : num;
        den_mag = den[WORD_W-1] ? -den : den;
        quo = num_mag / den_mag;
        if (num[WORD_W-1] ^ den[WORD_W-1]) begin
            quo = -quo;
        end
        return quo;
    endfunction

    task automatic evaluate_symbol(input logic [7:0] sym, input logic fin,
                                   output bit emitted, output out_beat_t res);
        logic [WORD_W-1:0] lhs;
        logic [WORD_W-1:0] rhs;
        emitted = 1'b0;
        res = '0;
        if (sym >= CHAR_ZERO && sym <= CHAR_NINE) begin
            mirror_push(32'(sym) - 32'(CHAR_ZERO));
        end else begin
            lhs = mirror_pop();
            rhs = mirror_pop();
            case (sym)
                CHAR_PLUS:  mirror_push(lhs + rhs);
                CHAR_MINUS: mirror_push(lhs - rhs);
                CHAR_STAR:  mirror_push(lhs * rhs);
                CHAR_SLASH: mirror_push(truncated_quotient(lhs, rhs));
                default:    ;
            endcase
        end
        if (fin) begin
            res.value = mirror_pop();
            res.underflow = mirror_underflow;
            res.divide_by_zero = mirror_div_zero;
            emitted = 1'b1;
            mirror_count = 0;
            mirror_underflow = 1'b0;
            mirror_div_zero = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_symbol(input logic [7:0] sym, input logic fin,
                               input bit typed, input out_beat_t typed_res);
        out_beat_t predicted;
        bit        emitted;
        int        gap;
        gap = pick_gap();
        if (gap > 0) begin
            expr_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        expr_valid <= 1'b1;
        expr_beat <= '{symbol: sym, final_symbol: fin};
        do @(posedge clk); while (expr_stall);
        evaluate_symbol(sym, fin, emitted, predicted);
        if (emitted) begin
            pending_results.push_back(typed ? typed_res : predicted);
        end
        sent_count++;
    endtask

    task automatic send_predicted(input logic [7:0] sym, input logic fin);
        send_symbol(sym, fin, 1'b0, '0);
    endtask

    task automatic wait_all_results();
        expr_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() > 0) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 19))
            0:       return 8'($urandom_range(0, 255));
            1, 2, 3, 4, 5:     return CHAR_PLUS;
            6, 7, 8, 9, 10:    return CHAR_MINUS;
            11, 12, 13, 14:    return CHAR_STAR;
            default: return CHAR_SLASH;
        endcase
    endfunction

    task automatic send_random_expression();
        int         kind;
        int         n;
        int         digits_left;
        int         ops_left;
        int         depth;
        int         op_pct;
        logic [7:0] sym;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                send_predicted(8'($urandom_range(0, 255)),
                               (i == n - 1) || ($urandom_range(0, 9) == 0));
            end
        end else begin
            digits_left = (kind < 17) ? $urandom_range(25, 40) : $urandom_range(1, 8);
            op_pct = (kind < 17) ? 10 : 50;
            ops_left = digits_left - 1;
            depth = 0;
            while (digits_left + ops_left > 0) begin
                if (depth >= 2 && ops_left > 0 &&
                    (digits_left == 0 || $urandom_range(0, 99) < op_pct)) begin
                    sym = pick_operator();
                    ops_left--;
                    depth--;
                end else begin
                    sym = digit_symbol($urandom_range(0, 9));
                    digits_left--;
                    depth++;
                end
                send_predicted(sym, digits_left + ops_left == 0);
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no expected result: value %h", result_beat.value);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (result_beat.value !== oldest_result.value) begin
                    $error("value: expected %h, actual %h",
                           oldest_result.value, result_beat.value);
                    error_count++;
                end
                if (result_beat.underflow !== oldest_result.underflow) begin
                    $error("underflow: expected %b, actual %b",
                           oldest_result.underflow, result_beat.underflow);
                    error_count++;
                end
                if (result_beat.divide_by_zero !== oldest_result.divide_by_zero) begin
                    $error("divide_by_zero: expected %b, actual %b",
                           oldest_result.divide_by_zero, result_beat.divide_by_zero);
                    error_count++;
                end
            end
        end
        stall_pick = $urandom_range(0, 99);
        if (stall_left > 0) begin
            result_stall <= 1'b1;
            stall_left--;
        end else if (steady || stall_pick < 55) begin
            result_stall <= 1'b0;
        end else if (stall_pick < 92) begin
            result_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end else begin
            result_stall <= 1'b1;
            stall_left = $urandom_range(15, 60);
        end
    end

    initial begin
        #10_000_000;
        $display("[prefix_expression_evaluator_unit] ERROR");
        $finish;
    end

    initial begin
        rst_n <= 1'b0;
        expr_valid <= 1'b0;
        expr_beat <= '0;
        result_stall <= 1'b0;
        mirror_count = 0;
        mirror_underflow = 1'b0;
        mirror_div_zero = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            send_symbol(directed_rows[i].symbol, directed_rows[i].final_symbol,
                        directed_rows[i].typed,
                        '{value: directed_rows[i].value,
                          underflow: directed_rows[i].underflow,
                          divide_by_zero: directed_rows[i].divide_by_zero});
        end
        wait_all_results();

        // A full stack drops the extra push; the most negative value divided by -1 wraps.
        for (int i = 0; i < STACK_SLOTS; i++) begin
            send_predicted(digit_symbol(1), 1'b0);
        end
        send_predicted(digit_symbol(7), 1'b0);
        send_predicted(CHAR_PLUS, 1'b1);
        send_predicted(digit_symbol(1), 1'b0);
        send_predicted(digit_symbol(0), 1'b0);
        send_predicted(CHAR_MINUS, 1'b0);
        send_predicted(digit_symbol(2), 1'b0);
        for (int i = 0; i < 10; i++) begin
            send_predicted(digit_symbol(8), 1'b0);
            send_predicted(CHAR_STAR, 1'b0);
        end
        send_predicted(CHAR_SLASH, 1'b1);

        sent_count = 0;
        while (sent_count < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 9) == 0);
            send_random_expression();
            if ($urandom_range(0, 49) == 0) begin
                wait_all_results();
            end
        end
        steady = 1'b0;
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("[prefix_expression_evaluator_unit] OK");
        end else begin
            $display("[prefix_expression_evaluator_unit] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/pee_pkg.sv
rtl/pee_stack_mem.sv
rtl/pee_divider.sv
rtl/prefix_expression_evaluator_unit.sv
verif/tb_prefix_expression_evaluator_unit.sv
